[hw/rtl/rch_pkg.sv]
package rch_pkg;

	localparam int MAX_BITS_DEF  = 5;
	localparam int ACC_WIDTH_DEF = 40;
	localparam int FIFO_DEPTH    = 2;

	// widest bin index over the whole MAX_BITS range (3 x 8)
	localparam int IDX_LIMIT_W = 24;
	localparam int AMT_W       = 16;
	localparam int BIN_VALUE_W = 40;
	localparam int READ_IDX_W  = 15;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_BITS      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTING = 1'b1;

	localparam logic [1:0] WT_ALL    = 2'd0;
	localparam logic [1:0] WT_MASK   = 2'd1;
	localparam logic [1:0] WT_WEIGHT = 2'd2;

	localparam logic MODE_ACC  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef struct packed {
		logic                        mode;
		logic [7:0]                  red;
		logic [7:0]                  green;
		logic [7:0]                  blue;
		logic                        mask_bit;
		logic signed [AMT_W-1:0]     weight;
		logic [READ_IDX_W-1:0]       bin_index;
	} pixel_t;

	typedef struct packed {
		logic [READ_IDX_W-1:0]       read_index;
		logic signed [BIN_VALUE_W-1:0] bin_value;
		logic                        saturated;
	} result_t;

	typedef struct packed {
		logic                        rd;
		logic [IDX_LIMIT_W-1:0]      idx;
		logic signed [AMT_W-1:0]     amount;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_UPDATE
	} back_state_t;

endpackage

[hw/rtl/rch_fifo.sv]
module rch_fifo
	import rch_pkg::*;
#(
	parameter type T     = logic,
	parameter int  DEPTH = FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     din,
	output logic full,
	input  logic pop,
	output T     dout,
	output logic empty
);

	// DEPTH must be a power of two, at least 2
	localparam int AW = $clog2(DEPTH);

	T              mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

endmodule

[hw/rtl/rch_front.sv]
module rch_front
	import rch_pkg::*;
#(
	parameter int MAX_BITS = MAX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pixel_t                pixel,
	output logic                  full,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  cmd_full,
	input  logic                  clearing,
	output logic                  cmd_push,
	output cmd_t                  cmd
);

	logic [2:0] bits_q;
	logic [1:0] wt_q;
	logic [3:0] eff_bits;
	logic [3:0] shift;
	logic [7:0] r_q8;
	logic [7:0] g_q8;
	logic [7:0] b_q8;
	logic [IDX_LIMIT_W-1:0] pix_idx;
	logic       cmd_valid;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full | clearing;
	assign cmd_push  = push & ~full & cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= 3'd4;
			wt_q   <= WT_ALL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BITS:      bits_q <= cfg_data[2:0];
				REG_WEIGHTING: wt_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bits_q == 3'd0)                   eff_bits = 4'd1;
		else if (4'(bits_q) > 4'(MAX_BITS))  eff_bits = 4'(MAX_BITS);
		else                                 eff_bits = 4'(bits_q);
		shift   = 4'd8 - eff_bits;
		r_q8    = pixel.red >> shift;
		g_q8    = pixel.green >> shift;
		b_q8    = pixel.blue >> shift;
		pix_idx = IDX_LIMIT_W'(r_q8) | (IDX_LIMIT_W'(g_q8) << eff_bits)
			| (IDX_LIMIT_W'(b_q8) << {eff_bits, 1'b0});
	end

	always_comb begin
		cmd_valid  = 1'b0;
		cmd.rd     = 1'b0;
		cmd.idx    = pix_idx;
		cmd.amount = AMT_W'(1);
		if (pixel.mode == MODE_READ) begin
			cmd_valid = 1'b1;
			cmd.rd    = 1'b1;
			cmd.idx   = IDX_LIMIT_W'(pixel.bin_index);
		end else begin
			case (wt_q)
				WT_ALL:    cmd_valid = 1'b1;
				WT_MASK:   cmd_valid = pixel.mask_bit;
				WT_WEIGHT: begin
					cmd_valid  = 1'b1;
					cmd.amount = pixel.weight;
				end
				default:   cmd_valid = 1'b0;
			endcase
		end
	end

endmodule

[hw/rtl/rch_back.sv]
module rch_back
	import rch_pkg::*;
#(
	parameter int MAX_BITS  = MAX_BITS_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_empty,
	output logic    cmd_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res,
	output logic    clearing
);

	localparam int IDX_W  = 3 * MAX_BITS;
	localparam int DEPTH  = 1 << IDX_W;
	localparam int WORD_W = ACC_WIDTH + 1;

	// word layout: saturation mark on top, accumulator below
	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_q;

	back_state_t       st_q;
	back_state_t       st_nxt;
	cmd_t              cur_q;
	logic [IDX_W-1:0]  clr_addr_q;
	logic [IDX_W-1:0]  cur_idx;
	logic              go;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [WORD_W-1:0] mem_wdata;

	logic [ACC_WIDTH-1:0] cur_val;
	logic [ACC_WIDTH-1:0] amt_ext;
	logic [ACC_WIDTH:0]   sum;
	logic                 ovf;
	logic [ACC_WIDTH-1:0] clamped;
	logic [63:0]          val_wide;

	assign cur_idx = cur_q.idx[IDX_W-1:0];
	assign go      = ~cmd_empty & (~cmd.rd | ~res_full);

	assign cur_val = rd_q[ACC_WIDTH-1:0];
	assign amt_ext = {{(ACC_WIDTH-AMT_W){cur_q.amount[AMT_W-1]}}, cur_q.amount};
	assign sum     = {cur_val[ACC_WIDTH-1], cur_val} + {amt_ext[ACC_WIDTH-1], amt_ext};
	assign ovf     = sum[ACC_WIDTH] ^ sum[ACC_WIDTH-1];
	always_comb begin
		if (!ovf)                clamped = sum[ACC_WIDTH-1:0];
		else if (sum[ACC_WIDTH]) clamped = {1'b1, {(ACC_WIDTH-1){1'b0}}};
		else                     clamped = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	end

	assign val_wide       = 64'(cur_val);
	assign res.read_index = READ_IDX_W'(cur_idx);
	assign res.bin_value  = val_wide[BIN_VALUE_W-1:0];
	assign res.saturated  = rd_q[ACC_WIDTH];

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			BK_CLEAR:  if (clr_addr_q == '1) st_nxt = BK_IDLE;
			BK_IDLE:   if (go) st_nxt = BK_UPDATE;
			BK_UPDATE: st_nxt = BK_IDLE;
			default:   st_nxt = BK_CLEAR;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_idx;
		mem_wdata = '0;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		clearing  = 1'b0;
		case (st_q)
			BK_CLEAR: begin
				clearing  = 1'b1;
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
			end
			BK_IDLE: cmd_pop = go;
			BK_UPDATE: begin
				mem_we   = 1'b1;
				res_push = cur_q.rd;
				if (!cur_q.rd) mem_wdata = {rd_q[ACC_WIDTH] | ovf, clamped};
			end
			default: clearing = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= BK_CLEAR;
			clr_addr_q <= '0;
		end else begin
			st_q <= st_nxt;
			if (st_q == BK_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) cur_q <= cmd;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[cmd.idx[IDX_W-1:0]];
	end

endmodule

[hw/rtl/rgb_color_histogram_top.sv]
// A read item passes through the command queue, then the back end's IDLE and UPDATE states,
// before its result is pushed into the result queue.
// Each command holds the back end for a read-modify-write of the bin memory
// (read, then update and write back); items masked out or with weighting off never enter the queue.
// Reset: asynchronous, active low. After reset a clearing pass zeroes all
// 2**(3*MAX_BITS) bins (32768 by default), while full stays high.
module rgb_color_histogram_top
	import rch_pkg::*;
#(
	parameter int MAX_BITS  = MAX_BITS_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pixel_t                pixel,
	output logic                  full,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd_in;
	cmd_t    cmd_head;
	logic    cmd_push;
	logic    cmd_full;
	logic    cmd_empty;
	logic    cmd_pop;
	result_t res;
	logic    res_push;
	logic    res_full;
	logic    clearing;

	rch_front #(
		.MAX_BITS (MAX_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pixel     (pixel),
		.full      (full),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_full  (cmd_full),
		.clearing  (clearing),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	rch_fifo #(
		.T     (cmd_t),
		.DEPTH (FIFO_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_head),
		.empty  (cmd_empty)
	);

	rch_back #(
		.MAX_BITS  (MAX_BITS),
		.ACC_WIDTH (ACC_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res),
		.clearing  (clearing)
	);

	rch_fifo #(
		.T     (result_t),
		.DEPTH (FIFO_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("item accepted during clearing pass");

	a_cmd_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command popped from empty queue");

	a_res_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	a_cmd_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command pushed into full queue");

endmodule

[bench/rgb_color_histogram_top_tb.sv]
module rgb_color_histogram_top_tb;
	import rch_pkg::*;

	localparam int          BIN_COUNT    = 1 << (3 * MAX_BITS_DEF);
	localparam longint      ACC_MAX      = (64'sd1 <<< (ACC_WIDTH_DEF - 1)) - 1;
	localparam longint      ACC_MIN      = -ACC_MAX - 1;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam logic [1:0]  WT_NONE      = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	pixel_t                pixel;
	logic                  full;
	logic                  empty;
	logic                  pop;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rgb_color_histogram_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pixel     (pixel),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// histogram shadow
	longint      hist_bins [BIN_COUNT];
	bit          sat_marks [BIN_COUNT];
	logic [2:0]  bits_reg;
	logic [1:0]  weighting_reg;
	result_t     bin_reads_expected [$];
	int unsigned hit_bins [$];
	int unsigned palette [4];

	int  mismatches;
	int  cycle_count;
	int  items_sent;
	bit  in_idle_on;
	bit  out_idle_on;
	int  stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pixel_bin(input pixel_t p);
		int unsigned b, sh, r, g, bl;
		b  = (bits_reg < 1) ? 1 : (bits_reg > MAX_BITS_DEF) ? MAX_BITS_DEF : bits_reg;
		sh = 8 - b;
		r  = p.red;
		g  = p.green;
		bl = p.blue;
		return ((r >> sh) | ((g >> sh) << b) | ((bl >> sh) << (2 * b))) & (BIN_COUNT - 1);
	endfunction

	function automatic void add_to_bin(input int unsigned idx, input longint amount);
		longint v;
		v = hist_bins[idx];
		if (amount > 0 && v > ACC_MAX - amount) begin
			hist_bins[idx] = ACC_MAX;
			sat_marks[idx] = 1'b1;
		end else if (amount < 0 && v < ACC_MIN - amount) begin
			hist_bins[idx] = ACC_MIN;
			sat_marks[idx] = 1'b1;
		end else begin
			hist_bins[idx] = v + amount;
		end
	endfunction

	function automatic void accumulate_pixel(input pixel_t p);
		int unsigned idx;
		longint      amount;
		result_t     r;
		if (p.mode == MODE_READ) begin
			idx          = p.bin_index & (BIN_COUNT - 1);
			r.read_index = READ_IDX_W'(idx);
			r.bin_value  = hist_bins[idx][BIN_VALUE_W-1:0];
			r.saturated  = sat_marks[idx];
			bin_reads_expected.push_back(r);
			hist_bins[idx] = 0;
			sat_marks[idx] = 1'b0;
		end else begin
			idx    = pixel_bin(p);
			amount = p.weight;
			case (weighting_reg)
				WT_ALL:    add_to_bin(idx, 1);
				WT_MASK:   if (p.mask_bit) add_to_bin(idx, 1);
				WT_WEIGHT: add_to_bin(idx, amount);
				default:   ;
			endcase
			hit_bins.push_back(idx);
			if (hit_bins.size() > 32)
				void'(hit_bins.pop_front());
		end
	endfunction

	function automatic pixel_t make_pixel(input logic mode, input logic [7:0] r, g, b,
			input logic mask, input logic signed [AMT_W-1:0] w, input int unsigned idx);
		pixel_t p;
		p.mode      = mode;
		p.red       = r;
		p.green     = g;
		p.blue      = b;
		p.mask_bit  = mask;
		p.weight    = w;
		p.bin_index = READ_IDX_W'(idx);
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got, exp);
		$display("ERROR cycle %0d: %s got 0x%0h, expected 0x%0h", cycle_count, what, got, exp);
		mismatches++;
	endtask

	task automatic send_pixel(input pixel_t p);
		int gap;
		gap = (in_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push  <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (full)
			@(posedge clk);
		accumulate_pixel(p);
		items_sent++;
	endtask

	task automatic read_bin(input int unsigned idx);
		send_pixel(make_pixel(MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom),
			1'($urandom), AMT_W'($urandom), idx));
	endtask

	task automatic acc_pixel(input logic [7:0] r, g, b, input logic mask,
			input logic signed [AMT_W-1:0] w);
		send_pixel(make_pixel(MODE_ACC, r, g, b, mask, w, $urandom));
	endtask

	// block is idle once all reads are back and the pipeline has settled
	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (bin_reads_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_BITS)
			bits_reg = data;
		else
			weighting_reg = data[1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result side: random pop stalls in bursts
	initial begin
		pop        = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				stall_left = $urandom_range(1, 11) - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (bin_reads_expected.size() == 0) begin
				report_mismatch("unexpected result, read_index", 64'(result.read_index),
					64'd0);
			end else begin
				want = bin_reads_expected.pop_front();
				if (result.read_index !== want.read_index)
					report_mismatch("read_index", 64'(result.read_index),
						64'(want.read_index));
				if (result.bin_value !== want.bin_value)
					report_mismatch("bin_value", 64'(result.bin_value),
						64'(want.bin_value));
				if (result.saturated !== want.saturated)
					report_mismatch("saturated", 64'(result.saturated),
						64'(want.saturated));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("rgb_color_histogram_top test failed");
			$finish;
		end
	end

	task automatic test_reset_state();
		pixel_t hi;
		hi = make_pixel(MODE_ACC, 8'hff, 8'hff, 8'hff, 1'b0, 16'sd0, 0);
		read_bin(0);
		read_bin(BIN_COUNT - 1);
		acc_pixel(8'h00, 8'h00, 8'h00, 1'b0, 16'sd0);
		send_pixel(hi);
		send_pixel(hi);
		read_bin(0);
		read_bin(pixel_bin(hi));
		wait_idle();
	endtask

	task automatic test_bits_limits();
		pixel_t p;
		p = make_pixel(MODE_ACC, 8'h80, 8'h00, 8'hff, 1'b1, -16'sd1, 15'h7fff);
		write_reg(REG_BITS, 3'd0);
		send_pixel(p);
		read_bin(pixel_bin(p));
		wait_idle();
		write_reg(REG_BITS, 3'd7);
		send_pixel(p);
		read_bin(pixel_bin(p));
		wait_idle();
		write_reg(REG_BITS, 3'd5);
	endtask

	task automatic test_weighting_modes();
		pixel_t p;
		p = make_pixel(MODE_ACC, 8'h3c, 8'ha5, 8'h5a, 1'b0, 16'sd0, 0);
		write_reg(REG_WEIGHTING, {1'b0, WT_MASK});
		send_pixel(p);
		p.mask_bit = 1'b1;
		send_pixel(p);
		read_bin(pixel_bin(p));
		wait_idle();
		write_reg(REG_WEIGHTING, {1'b1, WT_WEIGHT});
		p.weight = 16'sh7fff;
		send_pixel(p);
		send_pixel(p);
		p.weight = -16'sh8000;
		send_pixel(p);
		read_bin(pixel_bin(p));
		wait_idle();
		write_reg(REG_WEIGHTING, {1'b1, WT_NONE});
		send_pixel(p);
		read_bin(pixel_bin(p));
		wait_idle();
	endtask

	task automatic test_random_phases(input int n_phases, input int per_phase);
		pixel_t p;
		int     k;
		for (int ph = 0; ph < n_phases; ph++) begin
			in_idle_on  = (ph < n_phases - 1) && ($urandom_range(0, 4) != 0);
			out_idle_on = (ph < n_phases - 1) && ($urandom_range(0, 4) != 0);
			write_reg(REG_BITS, 3'($urandom_range(0, 7)));
			write_reg(REG_WEIGHTING, 3'($urandom_range(0, 7)));
			foreach (palette[j])
				palette[j] = $urandom;
			for (int i = 0; i < per_phase; i++) begin
				p = make_pixel(MODE_ACC, 8'($urandom), 8'($urandom), 8'($urandom),
					1'($urandom), AMT_W'($urandom), $urandom);
				k = $urandom_range(0, 7);
				if (k == 0)
					p.weight = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
				if ($urandom_range(0, 3) != 0) begin
					k = $urandom_range(0, 3);
					{p.red, p.green, p.blue} = palette[k][23:0];
				end
				if ($urandom_range(0, 3) == 0) begin
					p.mode = MODE_READ;
					if (hit_bins.size() != 0 && $urandom_range(0, 9) < 7)
						p.bin_index = READ_IDX_W'(
							hit_bins[$urandom_range(0, hit_bins.size() - 1)]);
				end
				send_pixel(p);
			end
			wait_idle();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		push          = 1'b0;
		pixel         = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		mismatches    = 0;
		cycle_count   = 0;
		items_sent    = 0;
		in_idle_on    = 1'b1;
		out_idle_on   = 1'b1;
		bits_reg      = 3'd4;
		weighting_reg = WT_ALL;
		foreach (hist_bins[i]) begin
			hist_bins[i] = 0;
			sat_marks[i] = 1'b0;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_bits_limits();
		test_weighting_modes();
		test_random_phases(8, 62);

		wait_idle();
		if (mismatches == 0) begin
			$display("rgb_color_histogram_top test passed");
		end else begin
			$display("rgb_color_histogram_top test failed");
		end
		$finish;
	end

endmodule
